[src/next_prime_search_macros.svh]
// Assertion macros for the next_prime_search checker.
`ifndef NEXT_PRIME_SEARCH_MACROS_SVH
`define NEXT_PRIME_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("next_prime_search: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next_prime_search: next-cycle check failed");

`endif

[src/nps_pkg.sv]
// Types and constants for the next-prime search block.
package nps_pkg;

    localparam int NUM_BITS  = 32;   // signed input width
    localparam int CAND_BITS = 31;   // candidate and result width
    localparam int DIV_BITS  = 16;   // trial divisor width
    localparam int SQ_BITS   = 32;   // divisor squared
    localparam int CNT_BITS  = 5;    // bit counter over the candidate

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TEST,
        ST_DIV,
        ST_REM,
        ST_VERDICT,
        ST_FINISH
    } nps_state_t;

endpackage

[src/next_prime_search.sv]
// Next-prime search: trial division with a bit-serial remainder unit.
// Each trial divisor runs a square test, 31 restoring-division steps over
// the candidate bits, and a remainder check.
// Run time grows with the divisors tried, summed over every candidate of the search.
// One request at a time; a new request is taken while the last result waits.
// rst_n clears the sequencer and the output valid asynchronously.
module next_prime_search #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [nps_pkg::NUM_BITS-1:0]   number,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  input_is_prime,
    output logic        [nps_pkg::CAND_BITS-1:0]  next_prime
);

    localparam int LIMIT_BITS = (NUMBER_BITS < nps_pkg::CAND_BITS) ?
                                NUMBER_BITS : nps_pkg::CAND_BITS;
    localparam logic [nps_pkg::CAND_BITS:0] LIMIT_WIDE =
        ((nps_pkg::CAND_BITS+1)'(1) << LIMIT_BITS) - (nps_pkg::CAND_BITS+1)'(1);
    localparam logic [nps_pkg::CAND_BITS-1:0] LIMIT =
        LIMIT_WIDE[nps_pkg::CAND_BITS-1:0];

    nps_pkg::nps_state_t state_reg, state_next;

    logic [nps_pkg::CAND_BITS-1:0] cand_reg, cand_next;
    logic                          self_phase_reg, self_phase_next;
    logic                          self_prime_reg, self_prime_next;
    logic                          trial_prime_reg, trial_prime_next;
    logic [nps_pkg::DIV_BITS-1:0]  div_reg, div_next;
    logic [nps_pkg::SQ_BITS-1:0]   sq_reg, sq_next;
    logic [nps_pkg::CAND_BITS-1:0] shift_reg, shift_next;
    logic [nps_pkg::DIV_BITS-1:0]  rem_reg, rem_next;
    logic [nps_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [nps_pkg::CAND_BITS-1:0] found_reg, found_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_prime_reg, out_prime_next;
    logic [nps_pkg::CAND_BITS-1:0] out_next_reg, out_next_next;

    logic [nps_pkg::DIV_BITS:0]    trial;
    logic                          trial_ge;
    logic                          out_free;

    assign trial    = {rem_reg, shift_reg[nps_pkg::CAND_BITS-1]};
    assign trial_ge = trial >= {1'b0, div_reg};
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall       = (state_reg != nps_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign input_is_prime = out_prime_reg;
    assign next_prime     = out_next_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nps_pkg::ST_IDLE;
            cand_reg        <= '0;
            self_phase_reg  <= 1'b0;
            self_prime_reg  <= 1'b0;
            trial_prime_reg <= 1'b0;
            div_reg         <= nps_pkg::DIV_BITS'(2);
            sq_reg          <= '0;
            shift_reg       <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            found_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cand_reg        <= cand_next;
            self_phase_reg  <= self_phase_next;
            self_prime_reg  <= self_prime_next;
            trial_prime_reg <= trial_prime_next;
            div_reg         <= div_next;
            sq_reg          <= sq_next;
            shift_reg       <= shift_next;
            rem_reg         <= rem_next;
            cnt_reg         <= cnt_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prime_reg <= out_prime_next;
        out_next_reg  <= out_next_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cand_next        = cand_reg;
        self_phase_next  = self_phase_reg;
        self_prime_next  = self_prime_reg;
        trial_prime_next = trial_prime_reg;
        div_next         = div_reg;
        sq_next          = sq_reg;
        shift_next       = shift_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        out_prime_next   = out_prime_reg;
        out_next_next    = out_next_reg;

        // drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (number[nps_pkg::NUM_BITS-1] ||
                        number[nps_pkg::CAND_BITS-1:0] < nps_pkg::CAND_BITS'(2))
                    begin
                        // not prime; search starts at two
                        self_prime_next = 1'b0;
                        self_phase_next = 1'b0;
                        cand_next       = nps_pkg::CAND_BITS'(2);
                    end
                    else
                    begin
                        self_phase_next = 1'b1;
                        cand_next       = number[nps_pkg::CAND_BITS-1:0];
                    end
                    state_next = nps_pkg::ST_START;
                end
            end

            nps_pkg::ST_START:
            begin
                div_next   = nps_pkg::DIV_BITS'(2);
                sq_next    = nps_pkg::SQ_BITS'(4);
                state_next = nps_pkg::ST_TEST;
            end

            nps_pkg::ST_TEST:
            begin
                if (sq_reg > {1'b0, cand_reg})
                begin
                    trial_prime_next = 1'b1;
                    state_next       = nps_pkg::ST_VERDICT;
                end
                else
                begin
                    shift_next = cand_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = nps_pkg::ST_DIV;
                end
            end

            nps_pkg::ST_DIV:
            begin
                // restoring step: bring in one candidate bit, subtract if it fits
                if (trial_ge)
                begin
                    rem_next = nps_pkg::DIV_BITS'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = trial[nps_pkg::DIV_BITS-1:0];
                end
                shift_next = {shift_reg[nps_pkg::CAND_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + nps_pkg::CNT_BITS'(1);
                if (cnt_reg == nps_pkg::CNT_BITS'(nps_pkg::CAND_BITS - 1))
                begin
                    state_next = nps_pkg::ST_REM;
                end
            end

            nps_pkg::ST_REM:
            begin
                if (rem_reg == '0)
                begin
                    trial_prime_next = 1'b0;
                    state_next       = nps_pkg::ST_VERDICT;
                end
                else
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    div_next   = div_reg + nps_pkg::DIV_BITS'(1);
                    sq_next    = sq_reg + nps_pkg::SQ_BITS'({div_reg, 1'b1});
                    state_next = nps_pkg::ST_TEST;
                end
            end

            nps_pkg::ST_VERDICT:
            begin
                if (self_phase_reg)
                begin
                    self_prime_next = trial_prime_reg;
                end
                self_phase_next = 1'b0;
                if (self_phase_reg && cand_reg > LIMIT)
                begin
                    found_next = '0;
                    state_next = nps_pkg::ST_FINISH;
                end
                else if (trial_prime_reg)
                begin
                    found_next = cand_reg;
                    state_next = nps_pkg::ST_FINISH;
                end
                else if (cand_reg >= LIMIT)
                begin
                    found_next = '0;
                    state_next = nps_pkg::ST_FINISH;
                end
                else
                begin
                    cand_next  = cand_reg + nps_pkg::CAND_BITS'(1);
                    state_next = nps_pkg::ST_START;
                end
            end

            nps_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = self_prime_reg;
                    out_next_next  = found_reg;
                    state_next     = nps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/nps_checker.sv]
// Port-level checker for next_prime_search, bound to the top level.
`include "next_prime_search_macros.svh"

module nps_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 input_is_prime,
    input logic [nps_pkg::CAND_BITS-1:0]        next_prime
);

    // a stalled result stays up
    `NPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a stalled result keeps its value
    `NPS_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                     $stable(next_prime) && $stable(input_is_prime))

    // the input side closes once a request is taken, while the search runs
    `NPS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

    // an even result is only two, or zero for no prime in range
    `NPS_ASSERT_SAME(a_no_even, out_valid && !next_prime[0],
                     next_prime == nps_pkg::CAND_BITS'(2) || next_prime == '0)

    // one is never a result
    `NPS_ASSERT_SAME(a_no_one, out_valid, next_prime != nps_pkg::CAND_BITS'(1))

endmodule

bind next_prime_search nps_checker u_nps_checker (.*);

[bench/tb_next_prime_search.sv]
// Testbench for next_prime_search: trial-division predictor with a queued stall-aware checker.
module tb_next_prime_search;

    // The largest input, a prime, dominates the run time; the rest stay small.
    localparam int unsigned CYCLE_LIMIT = 40_000_000;
    localparam int          SETTLE_CYCLES = 300;

    typedef struct {
        logic signed [nps_pkg::NUM_BITS-1:0] value;
        bit                                  wait_for_drain;
    } search_request_t;

    typedef struct packed {
        logic                          self_prime;
        logic [nps_pkg::CAND_BITS-1:0] prime;
    } prime_answer_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [nps_pkg::NUM_BITS-1:0]  number = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 input_is_prime;
    logic [nps_pkg::CAND_BITS-1:0]        next_prime;

    search_request_t requests_to_send[$];
    prime_answer_t   awaited_answers[$];

    int unsigned sent_count = 0;
    int unsigned done_count = 0;
    int unsigned stream_len = 1;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          send_gap_pct;
    int          recv_stall_pct;

    next_prime_search DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .number         (number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .input_is_prime (input_is_prime),
        .next_prime     (next_prime)
    );

    always #6 clk = ~clk;

    // Three thirds: receiver-heavy stalls, then sender-heavy gaps (rates swapped), then no idling.
    always_comb
    begin
        if (sent_count < stream_len / 3)
            send_gap_pct = 27;
        else if (sent_count < 2 * stream_len / 3)
            send_gap_pct = 45;
        else
            send_gap_pct = 0;
        if (done_count < stream_len / 3)
            recv_stall_pct = 45;
        else if (done_count < 2 * stream_len / 3)
            recv_stall_pct = 27;
        else
            recv_stall_pct = 0;
    end

    function automatic bit prime_by_trial(longint unsigned c);
        longint unsigned d;
        if (c <= 1)
            return 1'b0;
        for (d = 2; d * d <= c; d++)
        begin
            if (c % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic prime_answer_t predict_next_prime(
        logic signed [nps_pkg::NUM_BITS-1:0] n);
        prime_answer_t   r;
        longint unsigned c;
        r.self_prime = (n > 1) ? prime_by_trial({32'd0, n}) : 1'b0;
        // Search upward from 2 for anything at or below one.
        c = (n < 2) ? 64'd2 : {32'd0, n};
        while (!prime_by_trial(c))
            c++;
        r.prime = c[nps_pkg::CAND_BITS-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : drive_requests
        bit              took;
        search_request_t head;
        took = in_valid && !in_stall;
        if (took)
        begin
            awaited_answers.push_back(predict_next_prime(number));
            sent_count <= sent_count + 1;
        end
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took)
        begin
            // Hold a drain-marked request until every answer is back.
            if (requests_to_send.size() != 0
                && $urandom_range(0, 99) >= send_gap_pct
                && (!requests_to_send[0].wait_for_drain
                    || (!took && sent_count == done_count)))
            begin
                head = requests_to_send.pop_front();
                number   <= head.value;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_answers
        prime_answer_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                done_count <= done_count + 1;
                if (awaited_answers.size() == 0)
                    flag_mismatch($sformatf("unexpected answer prime=%0d is_prime=%0b",
                                            next_prime, input_is_prime));
                else
                begin
                    want = awaited_answers.pop_front();
                    if (input_is_prime !== want.self_prime)
                        flag_mismatch($sformatf("input_is_prime got %0b want %0b",
                                                input_is_prime, want.self_prime));
                    if (next_prime !== want.prime)
                        flag_mismatch($sformatf("next_prime got %0d want %0d",
                                                next_prime, want.prime));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_request(logic signed [nps_pkg::NUM_BITS-1:0] value, bit drain);
        search_request_t r;
        r.value = value;
        r.wait_for_drain = drain;
        requests_to_send.push_back(r);
    endtask

    initial
    begin
        int                                  pick;
        logic signed [nps_pkg::NUM_BITS-1:0] v;

        // Non-positive and one, smallest primes, squares, gaps, largest input.
        queue_request(32'sh8000_0000, 1'b0);
        queue_request(-1, 1'b0);
        queue_request(0, 1'b0);
        queue_request(1, 1'b0);
        queue_request(2, 1'b0);
        queue_request(3, 1'b0);
        queue_request(4, 1'b0);
        queue_request(9, 1'b0);
        queue_request(24, 1'b0);
        queue_request(25, 1'b0);
        queue_request(89, 1'b0);
        queue_request(90, 1'b0);
        queue_request(114, 1'b0);
        queue_request(121, 1'b0);
        queue_request(1000, 1'b0);
        queue_request(4093, 1'b0);
        queue_request(65521, 1'b0);
        queue_request(65535, 1'b0);
        queue_request(1048576, 1'b0);
        queue_request(32'sh7FFF_FFFF, 1'b0);

        for (int i = 0; i < 80; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                v = $urandom | 32'h8000_0000;
            else if (pick == 3)
                v = $urandom_range(0, 2);
            else if (pick < 15)
                v = $urandom_range(2, 4095);
            else if (pick < 19)
                v = $urandom_range(4096, 65535);
            else
                v = $urandom_range(65536, 1 << 20);
            queue_request(v, i == 0);
        end
        stream_len = requests_to_send.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_to_send.size() != 0 || in_valid || sent_count != done_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (awaited_answers.size() != 0)
            flag_mismatch($sformatf("%0d answers never arrived", awaited_answers.size()));

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
